// File: design/fbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fbs_pkg;

    localparam int BYTE_W    = 8;
    localparam int BLOCK_W   = 32;
    localparam int BPG_W     = 20;
    localparam int BPB_W     = 17;
    localparam int GROUP_W   = 32;
    localparam int LIMIT_W   = 33;
    localparam int COUNT_W   = 33;
    localparam int BYTE_IX_W = 16;
    localparam int BIT_W     = 3;
    localparam int CFG_W     = 33;
    localparam int REG_IX_W  = 2;

    localparam logic [BPG_W-1:0]   BPG_RESET   = BPG_W'(32768);
    localparam logic [BPB_W-1:0]   BPB_RESET   = BPB_W'(4096);
    localparam logic [GROUP_W-1:0] GROUPS_RESET = GROUP_W'(1);
    localparam logic [BPB_W-1:0]   BPB_MAX     = BPB_W'(65536);

    typedef enum logic [REG_IX_W-1:0] {
        REG_GROUP_SPAN       = 2'd0,
        REG_BYTES_PER_BITMAP = 2'd1,
        REG_GROUP_COUNT      = 2'd2,
        REG_FREE_LIMIT       = 2'd3
    } reg_ix_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // capture input byte
        logic load_base;  // compute base block number
        logic emit;       // push one result into the output register
        logic advance;    // step byte / group position
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic ignore;      // halted or past last group
        logic mask_empty;  // no free bits left in this byte
        logic last_bit;    // the bit at hand is the final free one
        logic over_limit;  // one more number would exceed the limit
        logic slot_free;   // output register can take a result
    } status_t;

endpackage

`default_nettype wire

// File: design/fbs_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fbs_byte_if;
    logic                          valid;
    logic                          ready;
    logic [fbs_pkg::BYTE_W-1:0]    bitmap_byte;

    modport source (output valid, output bitmap_byte, input ready);
    modport sink   (input valid, input bitmap_byte, output ready);
endinterface

interface fbs_result_if;
    logic                          valid;
    logic                          ready;
    logic [fbs_pkg::BLOCK_W-1:0]   block_number;
    logic                          overflow;
    logic                          last;

    modport source (output valid, output block_number, output overflow, output last,
                    input ready);
    modport sink   (input valid, input block_number, input overflow, input last,
                    output ready);
endinterface

`default_nettype wire

// File: design/free_bitmap_scanner.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                   Beat
// bitmap    in   bitmap_byte[7:0]                          one bitmap byte
// result    out  block_number[31:0], overflow, last        one free block number
// cfg       in   cfg_wr_en, cfg_index[1:0], cfg_data[32:0] one register write
//
// Steps: a scanned byte is taken, its base block number is computed by the
//   multiply, then each free (clear) bit gives one result out of the single
//   output register. A byte that is ignored is only taken.
// Reset: rst_n clears position, count, halt flag and output valid; config
//   registers return to their defaults.
// Stalls: result backpressure holds the emit step; the next byte is taken as
//   soon as the last result sits in the output register.

module free_bitmap_scanner (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    fbs_byte_if.sink                          bitmap,
    fbs_result_if.source                      result,
    input  wire logic                         cfg_wr_en,
    input  wire logic [fbs_pkg::REG_IX_W-1:0] cfg_index,
    input  wire logic [fbs_pkg::CFG_W-1:0]    cfg_data
);
    import fbs_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    in_ready;

    // sequencer: idle -> base multiply -> one emit per free bit
    fbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (bitmap.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // config, scan position, free count, bit picker and output register
    fbs_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .bitmap_byte (bitmap.bitmap_byte),
        .cmd         (cmd),
        .status      (status),
        .result      (result)
    );

    assign bitmap.ready = in_ready;

endmodule

`default_nettype wire

// File: design/fbs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fbs_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire fbs_pkg::status_t status,
    output fbs_pkg::cmd_t        cmd
);
    import fbs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && !status.ignore)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                cmd.load_base = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.mask_empty)
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (status.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.over_limit)
                    begin
                        state_next = S_IDLE;  // halts, position frozen
                    end
                    else if (status.last_bit)
                    begin
                        cmd.advance = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: design/fbs_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module fbs_dp (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [fbs_pkg::REG_IX_W-1:0] cfg_index,
    input  wire logic [fbs_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic [fbs_pkg::BYTE_W-1:0]   bitmap_byte,
    input  wire fbs_pkg::cmd_t                cmd,
    output fbs_pkg::status_t                  status,
    fbs_result_if.source                      result
);
    import fbs_pkg::*;

    // config
    logic [BPG_W-1:0]   bpg_reg;
    logic [BPB_W-1:0]   bpb_reg;
    logic [GROUP_W-1:0] groups_reg;
    logic [LIMIT_W-1:0] limit_reg;

    // scan position and counters
    logic [GROUP_W-1:0]   group_index_reg;
    logic [GROUP_W-1:0]   group_index_next;
    logic [BYTE_IX_W-1:0] byte_index_reg;
    logic [BYTE_IX_W-1:0] byte_index_next;
    logic [COUNT_W-1:0]   count_reg;
    logic                 halted_reg;

    // per-byte work
    logic [BYTE_W-1:0]  mask_reg;
    logic [BLOCK_W-1:0] base_reg;

    // output register
    logic               out_valid_reg;
    logic [BLOCK_W-1:0] out_number_reg;
    logic               out_ovf_reg;
    logic               out_last_reg;

    logic [BYTE_W-1:0]  lsb_onehot;
    logic [BYTE_W-1:0]  mask_rest;
    logic [BIT_W-1:0]   bit_pos;
    logic [COUNT_W:0]   count_inc;
    logic [BPB_W-1:0]   eff_bytes;
    logic [BPB_W-1:0]   byte_inc;
    logic [BLOCK_W-1:0] group_base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpg_reg    <= BPG_RESET;
            bpb_reg    <= BPB_RESET;
            groups_reg <= GROUPS_RESET;
            limit_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_ix_t'(cfg_index))
                REG_GROUP_SPAN:       bpg_reg    <= cfg_data[BPG_W-1:0];
                REG_BYTES_PER_BITMAP: bpb_reg    <= cfg_data[BPB_W-1:0];
                REG_GROUP_COUNT:      groups_reg <= cfg_data[GROUP_W-1:0];
                REG_FREE_LIMIT:       limit_reg  <= cfg_data[LIMIT_W-1:0];
                default:              bpg_reg    <= bpg_reg;
            endcase
        end
    end

    // lowest free bit of the byte
    assign lsb_onehot = mask_reg & (~mask_reg + BYTE_W'(1));
    assign mask_rest  = mask_reg & ~lsb_onehot;

    always_comb
    begin
        bit_pos = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (lsb_onehot[i])
            begin
                bit_pos = BIT_W'(i);
            end
        end
    end

    assign count_inc = {1'b0, count_reg} + (COUNT_W+1)'(1);

    // zero reads as one; 17-bit values past 65536 clamp
    always_comb
    begin
        if (bpb_reg == '0)
        begin
            eff_bytes = BPB_W'(1);
        end
        else if (bpb_reg > BPB_MAX)
        begin
            eff_bytes = BPB_MAX;
        end
        else
        begin
            eff_bytes = bpb_reg;
        end
    end

    assign byte_inc = {1'b0, byte_index_reg} + BPB_W'(1);

    always_comb
    begin
        if (byte_inc >= eff_bytes)
        begin
            byte_index_next  = '0;
            group_index_next = group_index_reg + GROUP_W'(1);
        end
        else
        begin
            byte_index_next  = byte_inc[BYTE_IX_W-1:0];
            group_index_next = group_index_reg;
        end
    end

    // low word of blocks_per_group * group_index
    assign group_base = BLOCK_W'(bpg_reg * group_index_reg);

    always_comb
    begin
        status.ignore     = halted_reg || (group_index_reg >= groups_reg);
        status.mask_empty = (mask_reg == '0);
        status.last_bit   = (mask_rest == '0);
        status.over_limit = count_inc > {1'b0, limit_reg};
        status.slot_free  = !out_valid_reg || result.ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mask_reg <= ~bitmap_byte;
        end
        else if (cmd.emit)
        begin
            mask_reg <= mask_rest;
        end
        if (cmd.load_base)
        begin
            base_reg <= group_base + BLOCK_W'({byte_index_reg, BIT_W'(0)});
        end
        if (cmd.emit)
        begin
            if (status.over_limit)
            begin
                out_number_reg <= '0;
                out_ovf_reg    <= 1'b1;
                out_last_reg   <= 1'b1;
            end
            else
            begin
                out_number_reg <= base_reg + BLOCK_W'(bit_pos);
                out_ovf_reg    <= 1'b0;
                out_last_reg   <= status.last_bit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_index_reg <= '0;
            byte_index_reg  <= '0;
            count_reg       <= '0;
            halted_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.advance)
            begin
                group_index_reg <= group_index_next;
                byte_index_reg  <= byte_index_next;
            end
            if (cmd.emit)
            begin
                if (status.over_limit)
                begin
                    halted_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_inc[COUNT_W-1:0];
                end
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.block_number = out_number_reg;
    assign result.overflow     = out_ovf_reg;
    assign result.last         = out_last_reg;

endmodule

`default_nettype wire
